@@ sv/array_queue_with_reverse_assert.svh @@
// Assertion macros for the array queue with reverse.
// Used by the RTL files that carry checks; no other dependencies.
`ifndef ARRAY_QUEUE_WITH_REVERSE_ASSERT_SVH
`define ARRAY_QUEUE_WITH_REVERSE_ASSERT_SVH
`ifndef SYNTHESIS
`define AQR_ASSERT(lbl, prop, clk, rst_n) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("aqr: property failed");
`define AQR_NEVER(lbl, cond, clk, rst_n) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("aqr: forbidden condition seen");
`else
`define AQR_ASSERT(lbl, prop, clk, rst_n)
`define AQR_NEVER(lbl, cond, clk, rst_n)
`endif
`endif

@@ sv/aqr_pkg.sv @@
// Shared types and constants for the array queue with reverse.
// No dependencies.
`timescale 1ns / 1ps
package aqr_pkg;

	localparam int DEPTH_DEF = 128;
	localparam int DATA_W = 32;

	localparam logic signed [DATA_W-1:0] DEQ_EMPTY_DATA = -32'sd1;

	typedef enum logic [1:0] {
		CMD_ENQ = 2'd0,
		CMD_DEQ = 2'd1,
		CMD_REV = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]               command;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		status_t                  status;
		logic                     is_empty;
		logic                     is_full;
	} rsp_t;

	// result stage handed from control to the output register
	typedef struct packed {
		logic vld;
		logic use_rd;
		rsp_t rsp;
	} s1_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_CP_RD,
		SQ_CP_WR,
		SQ_SW_RD_A,
		SQ_SW_RD_B,
		SQ_SW_WR_A,
		SQ_SW_WR_B
	} seq_t;

endpackage

@@ sv/aqr_mem.sv @@
// Entry storage: one write port, one read port, registered read data.
// Depends on aqr_pkg.
`timescale 1ns / 1ps
module aqr_mem #(
	parameter int DEPTH = aqr_pkg::DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [IDX_W-1:0]                 waddr,
	input  logic signed [aqr_pkg::DATA_W-1:0] wdata,
	input  logic                             re,
	input  logic [IDX_W-1:0]                 raddr,
	output logic signed [aqr_pkg::DATA_W-1:0] rdata
);

	logic signed [aqr_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic signed [aqr_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/aqr_ctrl.sv @@
// Command decode, head/tail/empty state and the reverse sequencer.
// Depends on aqr_pkg and array_queue_with_reverse_assert.svh; drives aqr_mem.
`timescale 1ns / 1ps
`include "array_queue_with_reverse_assert.svh"
module aqr_ctrl #(
	parameter int DEPTH = aqr_pkg::DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  aqr_pkg::req_t                     in_beat,
	input  logic                              adv,
	output aqr_pkg::s1_t                      s1,
	output logic                              mem_we,
	output logic [IDX_W-1:0]                  mem_waddr,
	output logic signed [aqr_pkg::DATA_W-1:0] mem_wdata,
	output logic                              mem_re,
	output logic [IDX_W-1:0]                  mem_raddr,
	input  logic signed [aqr_pkg::DATA_W-1:0] mem_rdata
);

	localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

	aqr_pkg::seq_t state_q, state_d;
	logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
	logic empty_q, empty_d;
	logic [IDX_W-1:0] src_q, src_d, dst_q, dst_d, end_q, end_d;
	logic [IDX_W-1:0] lo_q, lo_d, hi_q, hi_d;
	logic signed [aqr_pkg::DATA_W-1:0] hold_q, hold_d;
	logic vld_s1, vld_d;
	logic use_rd_s1, use_rd_d;
	aqr_pkg::rsp_t rsp_s1, rsp_d;
	logic accept, full;

	assign full = !empty_q && (tail_q == LAST);
	assign in_ready = (state_q == aqr_pkg::SQ_IDLE) && (!vld_s1 || adv);
	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		tail_d = tail_q;
		empty_d = empty_q;
		src_d = src_q;
		dst_d = dst_q;
		end_d = end_q;
		lo_d = lo_q;
		hi_d = hi_q;
		hold_d = hold_q;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = in_beat.value;
		mem_re = 1'b0;
		mem_raddr = '0;
		use_rd_d = 1'b0;
		rsp_d.data = '0;
		rsp_d.status = aqr_pkg::ST_OK;
		rsp_d.is_empty = 1'b0;
		rsp_d.is_full = 1'b0;
		case (state_q)
			aqr_pkg::SQ_IDLE: begin
				if (accept) begin
					case (in_beat.command)
						aqr_pkg::CMD_ENQ: begin
							if (full) begin
								rsp_d.status = aqr_pkg::ST_FULL;
							end else if (empty_q) begin
								mem_we = 1'b1;
								mem_waddr = '0;
								head_d = '0;
								tail_d = '0;
								empty_d = 1'b0;
							end else begin
								mem_we = 1'b1;
								mem_waddr = IDX_W'(tail_q + 1'b1);
								tail_d = IDX_W'(tail_q + 1'b1);
							end
						end
						aqr_pkg::CMD_DEQ: begin
							if (empty_q) begin
								rsp_d.data = aqr_pkg::DEQ_EMPTY_DATA;
								rsp_d.status = aqr_pkg::ST_EMPTY;
							end else begin
								mem_re = 1'b1;
								mem_raddr = head_q;
								use_rd_d = 1'b1;
								if (head_q >= tail_q) begin
									head_d = '0;
									tail_d = '0;
									empty_d = 1'b1;
								end else begin
									head_d = IDX_W'(head_q + 1'b1);
								end
							end
						end
						aqr_pkg::CMD_REV: begin
							if (!empty_q) begin
								head_d = '0;
								tail_d = IDX_W'(tail_q - head_q);
								lo_d = '0;
								hi_d = IDX_W'(tail_q - head_q);
								if (head_q != '0) begin
									// slide live entries down to slot 0 first
									src_d = head_q;
									dst_d = '0;
									end_d = tail_q;
									state_d = aqr_pkg::SQ_CP_RD;
								end else if (tail_q != '0) begin
									state_d = aqr_pkg::SQ_SW_RD_A;
								end
							end
						end
						default: begin
						end
					endcase
				end
				rsp_d.is_empty = empty_d;
				rsp_d.is_full = !empty_d && (tail_d == LAST);
			end
			aqr_pkg::SQ_CP_RD: begin
				mem_re = 1'b1;
				mem_raddr = src_q;
				state_d = aqr_pkg::SQ_CP_WR;
			end
			aqr_pkg::SQ_CP_WR: begin
				mem_we = 1'b1;
				mem_waddr = dst_q;
				mem_wdata = mem_rdata;
				if (src_q == end_q) begin
					state_d = (lo_q < hi_q) ? aqr_pkg::SQ_SW_RD_A : aqr_pkg::SQ_IDLE;
				end else begin
					src_d = IDX_W'(src_q + 1'b1);
					dst_d = IDX_W'(dst_q + 1'b1);
					state_d = aqr_pkg::SQ_CP_RD;
				end
			end
			aqr_pkg::SQ_SW_RD_A: begin
				mem_re = 1'b1;
				mem_raddr = lo_q;
				state_d = aqr_pkg::SQ_SW_RD_B;
			end
			aqr_pkg::SQ_SW_RD_B: begin
				mem_re = 1'b1;
				mem_raddr = hi_q;
				hold_d = mem_rdata;
				state_d = aqr_pkg::SQ_SW_WR_A;
			end
			aqr_pkg::SQ_SW_WR_A: begin
				mem_we = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = mem_rdata;
				state_d = aqr_pkg::SQ_SW_WR_B;
			end
			aqr_pkg::SQ_SW_WR_B: begin
				mem_we = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = hold_q;
				lo_d = IDX_W'(lo_q + 1'b1);
				hi_d = IDX_W'(hi_q - 1'b1);
				if (IDX_W'(lo_q + 1'b1) < IDX_W'(hi_q - 1'b1)) begin
					state_d = aqr_pkg::SQ_SW_RD_A;
				end else begin
					state_d = aqr_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = aqr_pkg::SQ_IDLE;
			end
		endcase
	end

	always_comb begin
		if (accept) begin
			vld_d = 1'b1;
		end else if (adv) begin
			vld_d = 1'b0;
		end else begin
			vld_d = vld_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aqr_pkg::SQ_IDLE;
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
			vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			empty_q <= empty_d;
			vld_s1 <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		src_q <= src_d;
		dst_q <= dst_d;
		end_q <= end_d;
		lo_q <= lo_d;
		hi_q <= hi_d;
		hold_q <= hold_d;
		if (accept) begin
			rsp_s1 <= rsp_d;
			use_rd_s1 <= use_rd_d;
		end
	end

	assign s1.vld = vld_s1;
	assign s1.use_rd = use_rd_s1;
	assign s1.rsp = rsp_s1;

	`AQR_ASSERT(a_empty_idx, empty_q |-> (head_q == '0 && tail_q == '0), clk, arst_n)
	`AQR_ASSERT(a_head_le_tail, !empty_q |-> (head_q <= tail_q), clk, arst_n)
	`AQR_ASSERT(a_swap_span, (state_q == aqr_pkg::SQ_SW_RD_A || state_q == aqr_pkg::SQ_SW_WR_B) |-> (lo_q < hi_q), clk, arst_n)
	`AQR_NEVER(a_rw_same_slot, mem_we && mem_re && (mem_waddr == mem_raddr), clk, arst_n)

endmodule

@@ sv/array_queue_with_reverse.sv @@
// Top level of the array queue with reverse: output register over aqr_ctrl and aqr_mem.
// Depends on aqr_pkg, aqr_ctrl and aqr_mem.
//
// Usage:
//   Input channel in_valid/in_ready/in_beat carries one command beat
//   (enqueue, dequeue, reverse). Output channel out_valid/out_ready/out_beat
//   returns exactly one result beat per command, in order.
//   Result path: an accepted command's result is registered first in the
//   stage s1 and then in the output register that drives out_beat (the entry
//   read for a dequeue lands in the memory's read register alongside s1).
//   Throughput: enqueue, dequeue and unused codes go one per cycle while the
//   output drains, as each needs at most one access of the single entry memory.
//   Reverse holds in_ready low while a sequencer rewrites the entries through
//   the same memory ports: it first slides the live entries down to slot 0,
//   reading then writing each (only when the head is not at slot 0), then
//   swaps entry pairs from both ends, then the next command is taken.
//   Reset: arst_n clears head and tail, sets the empty flag and drops both valids;
//   entry contents are left as they are and never read before written.
//   Stall: while out_ready is low the result stays in the output register,
//   one more result waits in the stage behind it, and then in_ready drops.
`timescale 1ns / 1ps
module array_queue_with_reverse #(
	parameter int DEPTH = aqr_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  aqr_pkg::req_t in_beat,
	output logic          out_valid,
	input  logic          out_ready,
	output aqr_pkg::rsp_t out_beat
);

	localparam int IDX_W = $clog2(DEPTH);

	aqr_pkg::s1_t s1;
	logic out_free;
	logic out_vld_q;
	aqr_pkg::rsp_t out_q;

	// memory port wires
	logic mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	logic signed [aqr_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

	// the output register can take a new result when empty or being drained
	assign out_free = !out_vld_q || out_ready;

	aqr_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.adv      (out_free),
		.s1       (s1),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	aqr_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= s1.vld;
		end
	end

	// dequeue data comes straight from the memory read register
	always_ff @(posedge clk) begin
		if (out_free && s1.vld) begin
			out_q.data <= s1.use_rd ? mem_rdata : s1.rsp.data;
			out_q.status <= s1.rsp.status;
			out_q.is_empty <= s1.rsp.is_empty;
			out_q.is_full <= s1.rsp.is_full;
		end
	end

	assign out_valid = out_vld_q;
	assign out_beat = out_q;

endmodule

@@ sim/aqr_result_checker.sv @@
// Result checker for array_queue_with_reverse: follows both channels, keeps its own queue
// model, and compares every result beat with the predicted one. Depends on aqr_pkg.
`timescale 1ns / 1ps
module aqr_result_checker
	import aqr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  req_t in_beat,
	input  logic out_valid,
	input  logic out_ready,
	input  rsp_t out_beat,
	output int   mismatches,
	output int   outstanding
);

	localparam int IDX_W = $clog2(DEPTH_DEF);

	logic signed [DATA_W-1:0] slots [DEPTH_DEF];
	logic [IDX_W-1:0]         head_idx;
	logic [IDX_W-1:0]         tail_idx;
	logic                     queue_empty;

	rsp_t expected_results[$];
	rsp_t want;
	int   bad_beats;
	int   beat_no;

	function automatic logic queue_full();
		return !queue_empty && int'(tail_idx) == DEPTH_DEF - 1;
	endfunction

	// applies one command to the model and returns the result it should give
	function automatic rsp_t predict_queue_step(req_t req);
		rsp_t                     r;
		logic signed [DATA_W-1:0] flipped [DEPTH_DEF];
		int                       n;
		r.data     = '0;
		r.status   = ST_OK;
		r.is_empty = 1'b0;
		r.is_full  = 1'b0;
		case (req.command)
			CMD_ENQ: begin
				if (queue_full()) begin
					r.status = ST_FULL;
				end else if (queue_empty) begin
					head_idx    = '0;
					tail_idx    = '0;
					slots[0]    = req.value;
					queue_empty = 1'b0;
				end else begin
					tail_idx        = tail_idx + 1'b1;
					slots[tail_idx] = req.value;
				end
			end
			CMD_DEQ: begin
				if (queue_empty) begin
					r.data   = DEQ_EMPTY_DATA;
					r.status = ST_EMPTY;
				end else begin
					r.data = slots[head_idx];
					if (head_idx >= tail_idx) begin
						head_idx    = '0;
						tail_idx    = '0;
						queue_empty = 1'b1;
					end else begin
						head_idx = head_idx + 1'b1;
					end
				end
			end
			CMD_REV: begin
				if (!queue_empty) begin
					n = int'(tail_idx) - int'(head_idx) + 1;
					for (int i = 0; i < n; i++)
						flipped[i] = slots[int'(tail_idx) - i];
					for (int i = 0; i < n; i++)
						slots[i] = flipped[i];
					head_idx = '0;
					tail_idx = IDX_W'(n - 1);
				end
			end
			default: ;
		endcase
		r.is_empty = queue_empty;
		r.is_full  = queue_full();
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_idx    = '0;
			tail_idx    = '0;
			queue_empty = 1'b1;
			bad_beats   = 0;
			beat_no     = 0;
			expected_results.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// check the result first: a result never leaves in the cycle its command enters
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("result beat %0d arrived with nothing pending: data=%0d status=%0d empty=%b full=%b",
							beat_no, out_beat.data, out_beat.status, out_beat.is_empty,
							out_beat.is_full);
				end else begin
					want = expected_results.pop_front();
					if (out_beat.data !== want.data || out_beat.status !== want.status ||
							out_beat.is_empty !== want.is_empty ||
							out_beat.is_full !== want.is_full) begin
						bad_beats++;
						if (bad_beats <= 10)
							$display("result beat %0d: expected data=%0d status=%0d empty=%b full=%b, got data=%0d status=%0d empty=%b full=%b",
								beat_no, want.data, want.status, want.is_empty, want.is_full,
								out_beat.data, out_beat.status, out_beat.is_empty,
								out_beat.is_full);
					end
				end
				beat_no++;
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict_queue_step(in_beat));
			mismatches  <= bad_beats;
			outstanding <= expected_results.size();
		end
	end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for array_queue_with_reverse: clock, reset, command stimulus, result-side
// backpressure, watchdog and verdict. Depends on aqr_pkg, the block and aqr_result_checker.
`timescale 1ns / 1ps
module tb_top;
	import aqr_pkg::*;

	// code 3 is not a command; the block must pass it through as a no-op
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int NUM_RANDOM     = 2000;
	localparam int CALM_TAIL      = 300;   // last beats sent with no idling on either side
	localparam int WATCHDOG_LIMIT = 5000;  // must outlast a full reverse and the longest stall
	localparam int DRAIN_CYCLES   = 10;

	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

	typedef enum {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIXED
	} mode_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_beat;
	logic out_valid;
	logic out_ready;
	rsp_t out_beat;

	int mismatches;
	int outstanding;
	int idle_cycles = 0;
	bit calm = 1'b0;

	array_queue_with_reverse DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_beat (out_beat)
	);

	aqr_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_beat    (in_beat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_beat   (out_beat),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drive one command beat and hold it until the block takes it. Called at a
	// rising edge; returns at the edge where the beat was accepted, so the next
	// beat can be put up right away with valid left high.
	task automatic send_beat(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val);
		in_valid <= 1'b1;
		in_beat  <= '{command: cmd, value: val};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stop sending and wait until every predicted result has been returned.
	// The checker's count is registered, hence the first wait.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Mode decides how the queue level drifts: fill pushes toward full,
	// drain toward empty, mixed wanders around. Reverse and the unused
	// code sprinkle in everywhere.
	function automatic logic [1:0] pick_command(mode_t mode);
		int r;
		int enq_cut;
		int deq_cut;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				enq_cut = 88;
				deq_cut = 94;
			end
			MODE_DRAIN: begin
				enq_cut = 12;
				deq_cut = 92;
			end
			default: begin
				enq_cut = 45;
				deq_cut = 88;
			end
		endcase
		if (r < enq_cut)
			return CMD_ENQ;
		else if (r < deq_cut)
			return CMD_DEQ;
		else if (r < 98)
			return CMD_REV;
		else
			return CMD_UNUSED;
	endfunction

	// mostly random words, now and then one of the extremes
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return WORD_MAX;
			1:       return WORD_MIN;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Stimulus
	initial begin
		mode_t mode;
		int    seg_left;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_beat  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corner cases on an empty queue first
		send_beat(CMD_DEQ, 32'sd5);        // dequeue on empty -> -1, status empty
		send_beat(CMD_REV, 32'sd0);        // reverse on empty does nothing
		send_beat(CMD_UNUSED, WORD_MAX);   // unused code, empty queue
		send_beat(CMD_ENQ, WORD_MAX);      // first enqueue lands in slot 0
		send_beat(CMD_ENQ, WORD_MIN);
		send_beat(CMD_ENQ, '0);
		send_beat(CMD_ENQ, -32'sd1);
		send_beat(CMD_UNUSED, WORD_MIN);   // unused code with entries live
		send_beat(CMD_REV, 32'sd0);        // head already at slot 0: swaps only
		send_beat(CMD_DEQ, 32'sd0);
		send_beat(CMD_REV, 32'sd0);        // head past slot 0: slide down, then swap
		send_beat(CMD_DEQ, 32'sd0);
		send_beat(CMD_DEQ, 32'sd0);
		send_beat(CMD_DEQ, 32'sd0);        // last entry out: indices back to 0
		wait_drained();
		send_beat(CMD_ENQ, 32'sh5555_5555);
		send_beat(CMD_ENQ, 32'shAAAA_AAAA);
		send_beat(CMD_REV, 32'sd0);        // two entries
		send_beat(CMD_DEQ, 32'sd0);
		send_beat(CMD_REV, 32'sd0);        // single entry
		send_beat(CMD_DEQ, 32'sd0);
		send_beat(CMD_DEQ, 32'sd0);        // empty again

		// Random: segments of one mode each. The first is a long fill so the
		// queue reaches the last slot (enqueue when full) early on.
		mode     = MODE_FILL;
		seg_left = 200;
		for (int k = 0; k < NUM_RANDOM; k++) begin
			if (seg_left == 0) begin
				if (k < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0)
					wait_drained();
				mode     = mode_t'($urandom_range(0, 2));
				seg_left = $urandom_range(20, 250);
			end
			seg_left--;
			if (k == NUM_RANDOM - CALM_TAIL)
				calm <= 1'b1;
			if (k < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			send_beat(pick_command(mode), pick_value());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("array_queue_with_reverse: match");
		else
			$display("array_queue_with_reverse: mismatch");
		$finish;
	end

	// Result side: ready stalls come in bursts; the stall rate itself changes now
	// and then, dropping to zero at times for clean stretches.
	initial begin
		int stall_pct;
		stall_pct = 20;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ready <= 1'b1;
			if ($urandom_range(0, 63) == 0)
				stall_pct = $urandom_range(0, 40);
			@(posedge clk);
		end
	end

	// Watchdog: too long without a beat moving on either channel ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("array_queue_with_reverse: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
